FILE: hdl/ppoc_pkg.sv
package ppoc_pkg;

    // sizes of the two stores
    localparam int MAX_PIXELS    = 524288;
    localparam int PALETTE_DEPTH = 256;
    localparam int PIX_AW        = $clog2(MAX_PIXELS);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    // command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTENT_X,
        REG_CONTENT_Y,
        REG_CONTENT_WIDTH,
        REG_CONTENT_HEIGHT,
        REG_PALETTE_COUNT
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_BLEND = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_SKIPPED = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } status_t;

    // what the back end has to do with a word
    typedef enum logic [2:0] {
        KIND_CLEAR,
        KIND_LOAD,
        KIND_READ,
        KIND_BLEND,
        KIND_SKIP_BLEND,
        KIND_SKIP_LOAD,
        KIND_OUTSIDE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [PIX_AW-1:0] addr;
        logic [PAL_AW-1:0] pal_idx;
        logic [31:0]       color;
    } queue_entry_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_EXEC,
        BACK_MIX
    } back_state_t;

    // exact floor(v / 255) for v below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: hdl/ppoc_ram.sv
module ppoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/ppoc_front.sv
module ppoc_front import ppoc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,
    input  logic [1:0]             s_tuser,
    // configuration writes
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // to the queue
    output logic                   q_push_valid,
    input  logic                   q_push_ready,
    output queue_entry_t           q_push_entry
);

    logic [11:0] content_x_reg;
    logic [11:0] content_y_reg;
    logic [12:0] content_width_reg;
    logic [12:0] content_height_reg;
    logic [8:0]  palette_count_reg;

    logic        f_valid_reg, f_valid_next;
    cmd_t        f_cmd_reg;
    logic [11:0] f_dx_reg;
    logic [11:0] f_dy_reg;
    logic [7:0]  f_idx_reg;
    logic [31:0] f_color_reg;
    logic        f_in_box_reg;
    logic        f_blend_ok_reg;
    logic        f_load_ok_reg;

    logic        s_accept;
    logic [11:0] in_x;
    logic [11:0] in_y;
    logic [7:0]  in_idx;
    logic        in_box;
    logic [24:0] row_prod;
    logic [25:0] addr_sum;
    logic        in_store;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            content_x_reg      <= '0;
            content_y_reg      <= '0;
            content_width_reg  <= '0;
            content_height_reg <= '0;
            palette_count_reg  <= '0;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_CONTENT_X:      content_x_reg      <= cfg_data[11:0];
                REG_CONTENT_Y:      content_y_reg      <= cfg_data[11:0];
                REG_CONTENT_WIDTH:  content_width_reg  <= cfg_data;
                REG_CONTENT_HEIGHT: content_height_reg <= cfg_data;
                REG_PALETTE_COUNT:  palette_count_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // input word fields
    assign in_x   = s_tdata[11:0];
    assign in_y   = s_tdata[23:12];
    assign in_idx = s_tdata[31:24];

    assign s_tready = !f_valid_reg || q_push_ready;
    assign s_accept = s_tvalid && s_tready;

    // box test on the incoming coordinates
    assign in_box = (in_x >= content_x_reg) && (in_y >= content_y_reg)
                 && (14'(in_x) < 14'(content_x_reg) + 14'(content_width_reg))
                 && (14'(in_y) < 14'(content_y_reg) + 14'(content_height_reg));

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_accept) begin
            f_valid_next = 1'b1;
        end else if (q_push_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    // first stage: offsets and range checks
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            f_cmd_reg      <= cmd_t'(s_tuser);
            f_dx_reg       <= in_x - content_x_reg;
            f_dy_reg       <= in_y - content_y_reg;
            f_idx_reg      <= in_idx;
            f_color_reg    <= s_tdata[63:32];
            f_in_box_reg   <= in_box;
            f_blend_ok_reg <= (9'(in_idx) < palette_count_reg)
                           && (9'(in_idx) < 9'(PALETTE_DEPTH));
            f_load_ok_reg  <= 9'(in_idx) < 9'(PALETTE_DEPTH);
        end
    end

    // second stage: store address and classification
    assign row_prod = 25'(f_dy_reg) * 25'(content_width_reg);
    assign addr_sum = 26'(row_prod) + 26'(f_dx_reg);
    assign in_store = addr_sum < 26'(MAX_PIXELS);

    always_comb begin
        q_push_entry.addr    = addr_sum[PIX_AW-1:0];
        q_push_entry.pal_idx = f_idx_reg[PAL_AW-1:0];
        q_push_entry.color   = f_color_reg;
        q_push_entry.kind    = KIND_OUTSIDE;
        if (f_cmd_reg == CMD_LOAD) begin
            q_push_entry.kind = f_load_ok_reg ? KIND_LOAD : KIND_SKIP_LOAD;
        end else if (f_in_box_reg && in_store) begin
            case (f_cmd_reg)
                CMD_CLEAR: q_push_entry.kind = KIND_CLEAR;
                CMD_READ:  q_push_entry.kind = KIND_READ;
                CMD_BLEND: q_push_entry.kind = f_blend_ok_reg ? KIND_BLEND
                                                              : KIND_SKIP_BLEND;
                default:   q_push_entry.kind = KIND_OUTSIDE;
            endcase
        end
    end

    assign q_push_valid = f_valid_reg;

endmodule

FILE: hdl/ppoc_queue.sv
module ppoc_queue import ppoc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output queue_entry_t pop_entry
);

    queue_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/ppoc_back.sv
module ppoc_back import ppoc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // from the queue
    input  logic         pop_valid,
    output logic         pop_ready,
    input  queue_entry_t pop_entry,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,
    output logic [1:0]   m_tuser
);

    back_state_t  state_reg, state_next;
    queue_entry_t item_reg, item_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  out_pixel_reg, out_pixel_next;
    status_t      out_status_reg, out_status_next;
    logic [15:0]  ps_reg [4];
    logic [15:0]  ps_next [4];
    logic [15:0]  pd_reg [4];
    logic [15:0]  pd_next [4];

    logic         frame_wr_en;
    logic [31:0]  frame_wr_data;
    logic [31:0]  frame_rd_data;
    logic         pal_wr_en;
    logic [31:0]  pal_rd_data;
    logic         do_pop;
    logic [7:0]   alpha;
    logic [7:0]   inv_alpha;
    logic [7:0]   src_byte;
    logic [31:0]  mixed;

    assign alpha     = pal_rd_data[31:24];
    assign inv_alpha = 8'hff - alpha;
    assign do_pop    = pop_valid && pop_ready;

    // frame store
    ppoc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PIXELS)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (frame_wr_en),
        .wr_addr (item_reg.addr),
        .wr_data (frame_wr_data),
        .rd_en   (do_pop),
        .rd_addr (pop_entry.addr),
        .rd_data (frame_rd_data)
    );

    // palette store
    ppoc_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_ram (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (item_reg.pal_idx),
        .wr_data (item_reg.color),
        .rd_en   (do_pop),
        .rd_addr (pop_entry.pal_idx),
        .rd_data (pal_rd_data)
    );

    // channel products: premultiply source, scale destination by 255 - alpha
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            src_byte    = (ch == 3) ? 8'hff : pal_rd_data[ch*8 +: 8];
            ps_next[ch] = 16'(src_byte) * 16'(alpha);
            pd_next[ch] = 16'(frame_rd_data[ch*8 +: 8]) * 16'(inv_alpha);
        end
    end

    // over rule sums
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            mixed[ch*8 +: 8] = div255(ps_reg[ch]) + div255(pd_reg[ch]);
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pixel_next  = out_pixel_reg;
        out_status_next = out_status_reg;
        pop_ready       = 1'b0;
        frame_wr_en     = 1'b0;
        frame_wr_data   = mixed;
        pal_wr_en       = 1'b0;
        case (state_reg)
            BACK_IDLE: begin
                pop_ready = !out_valid_reg || m_tready;
                if (pop_valid && pop_ready) begin
                    item_next  = pop_entry;
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC: begin
                state_next      = BACK_IDLE;
                out_valid_next  = 1'b1;
                out_pixel_next  = '0;
                out_status_next = STATUS_DONE;
                case (item_reg.kind)
                    KIND_CLEAR: begin
                        frame_wr_en   = 1'b1;
                        frame_wr_data = '0;
                    end
                    KIND_LOAD: begin
                        pal_wr_en = 1'b1;
                    end
                    KIND_READ: begin
                        out_pixel_next = frame_rd_data;
                    end
                    KIND_SKIP_BLEND: begin
                        out_pixel_next  = frame_rd_data;
                        out_status_next = STATUS_SKIPPED;
                    end
                    KIND_SKIP_LOAD: begin
                        out_status_next = STATUS_SKIPPED;
                    end
                    KIND_BLEND: begin
                        out_valid_next = 1'b0;
                        state_next     = BACK_MIX;
                    end
                    default: begin
                        out_status_next = STATUS_OUTSIDE;
                    end
                endcase
            end
            BACK_MIX: begin
                frame_wr_en     = 1'b1;
                out_valid_next  = 1'b1;
                out_pixel_next  = mixed;
                out_status_next = STATUS_DONE;
                state_next      = BACK_IDLE;
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        out_pixel_reg  <= out_pixel_next;
        out_status_reg <= out_status_next;
        if (state_reg == BACK_EXEC) begin
            ps_reg <= ps_next;
            pd_reg <= pd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: hdl/palette_pixel_over_compositor_core.sv
// channel    direction  tdata (low bit up)                          tuser
// s_         in         x[11:0] y[23:12] palette_index[31:24]       command[1:0]
//                       palette_color[63:32]
// m_         out        pixel_bgra[31:0]                            status[1:0]
// cfg_       in         cfg_index selects register, cfg_data value  -
//
// a word passes the front register (box test before it, row multiply after it),
// the queue and the back sequencer states IDLE and EXEC, plus MIX for a blend;
// the back end takes one word at a time; m_tvalid comes from out_valid_reg, set
// in EXEC, or in MIX for a blend
// reset clears control state only; the frame and palette stores start undefined
// the queue lets the front keep accepting while the back or m_ side stalls, until it is full
module palette_pixel_over_compositor_core import ppoc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // x, y, palette_index, palette_color
    input  logic [1:0]             s_tuser,   // command
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // pixel_bgra
    output logic [1:0]             m_tuser,   // status
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic         q_push_valid;
    logic         q_push_ready;
    queue_entry_t q_push_entry;
    logic         q_pop_valid;
    logic         q_pop_ready;
    queue_entry_t q_pop_entry;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // front: config, box test, address
    ppoc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_push_valid (q_push_valid),
        .q_push_ready (q_push_ready),
        .q_push_entry (q_push_entry)
    );

    // command queue
    ppoc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_entry (q_push_entry),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_entry  (q_pop_entry)
    );

    // back: stores, blend, result register
    ppoc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_entry (q_pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
